FILE: rtl/ssq_pkg.sv
// Shared types, constants and helper functions of the scaled size quantizer.
package ssq_pkg;

  localparam int MAX_ALLOWED = 8;
  localparam int DIV_STEPS   = 17;

  localparam logic [19:0] ONE_Q8    = 20'd256;
  localparam logic [19:0] SCALE_MAX = 20'hFFFFF;
  localparam logic [29:0] OUT_MAX   = 30'h3FFFFFFF;

  // Configuration register indexes.
  localparam logic [2:0] REG_SCALE      = 3'd0;
  localparam logic [2:0] REG_GROW       = 3'd1;
  localparam logic [2:0] REG_SHRINK     = 3'd2;
  localparam logic [2:0] REG_STEPPING   = 3'd3;
  localparam logic [2:0] REG_ROUNDING   = 3'd4;
  localparam logic [2:0] REG_COUNT      = 3'd5;
  localparam logic [2:0] REG_SIZES_LOW  = 3'd6;
  localparam logic [2:0] REG_SIZES_HIGH = 3'd7;

  // Rounding modes.
  localparam logic [1:0] RND_NEAR = 2'd0;
  localparam logic [1:0] RND_UP   = 2'd1;
  localparam logic [1:0] RND_DOWN = 2'd2;

  typedef struct packed {
    logic [19:0]  scale;
    logic [19:0]  g_thr;
    logic [19:0]  g_ratio;
    logic [19:0]  g_lim;
    logic [19:0]  s_thr;
    logic [19:0]  s_ratio;
    logic [19:0]  s_lim;
    logic [19:0]  stepping;
    logic [1:0]   rounding;
    logic [3:0]   count;
    logic [127:0] sizes;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_REMAP,
    OP_UP_STEP,
    OP_DN_START,
    OP_DN_BIT,
    OP_DN_END,
    OP_LAD_PICK,
    OP_SCALE_MUL,
    OP_TAB_INIT,
    OP_TAB_STEP,
    OP_FINAL
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REMAP,
    ST_LAD_SEL,
    ST_UP,
    ST_DN_CHK,
    ST_DN_DIV,
    ST_DN_END,
    ST_PICK,
    ST_MUL,
    ST_TAB_INIT,
    ST_TAB,
    ST_FINAL
  } state_e;

  typedef struct packed {
    logic bypass;
    logic v_gt_one;
    logic up_more;
    logic dn_more;
    logic div_last;
    logic tab_en;
    logic tab_busy;
  } dp_status_t;

  // Choose between the two neighbors of v under the rounding mode.
  function automatic logic [42:0] pick(input logic [42:0] v, input logic [42:0] lo,
                                       input logic [42:0] hi, input logic [1:0] rnd);
    logic [42:0] r;
    case (rnd)
      RND_UP:   r = hi;
      RND_DOWN: r = lo;
      RND_NEAR: r = ((v > lo) && ((v - lo) > (hi - v))) ? hi : lo;
      default:  r = v;
    endcase
    return r;
  endfunction

  // One allowed size, widened to Q.8.
  function automatic logic [19:0] entry(input logic [127:0] sizes, input logic [2:0] i);
    return {sizes[{i, 4'b0} +: 16], 4'b0};
  endfunction

endpackage

FILE: rtl/ssq_regs.sv
// Configuration register file of the scaled size quantizer.
module ssq_regs import ssq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  // Register writes, one per enabled cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale    <= ONE_Q8;
      cfg_q.g_thr    <= ONE_Q8;
      cfg_q.g_ratio  <= ONE_Q8;
      cfg_q.g_lim    <= 20'd262144;
      cfg_q.s_thr    <= ONE_Q8;
      cfg_q.s_ratio  <= ONE_Q8;
      cfg_q.s_lim    <= '0;
      cfg_q.stepping <= '0;
      cfg_q.rounding <= RND_NEAR;
      cfg_q.count    <= '0;
      cfg_q.sizes    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SCALE:    cfg_q.scale <= cfg_data_i[19:0];
        REG_GROW: begin
          cfg_q.g_thr   <= cfg_data_i[19:0];
          cfg_q.g_ratio <= cfg_data_i[39:20];
          cfg_q.g_lim   <= cfg_data_i[59:40];
        end
        REG_SHRINK: begin
          cfg_q.s_thr   <= cfg_data_i[19:0];
          cfg_q.s_ratio <= cfg_data_i[39:20];
          cfg_q.s_lim   <= cfg_data_i[59:40];
        end
        REG_STEPPING:   cfg_q.stepping <= cfg_data_i[19:0];
        REG_ROUNDING:   cfg_q.rounding <= cfg_data_i[1:0];
        REG_COUNT:      cfg_q.count <= cfg_data_i[3:0];
        REG_SIZES_LOW:  cfg_q.sizes[63:0] <= cfg_data_i;
        REG_SIZES_HIGH: cfg_q.sizes[127:64] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/ssq_ctrl.sv
// Sequencing state machine of the scaled size quantizer.
module ssq_ctrl import ssq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t st_i,
  output op_e        op_o,
  output logic       busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (start_i) state_d = ST_REMAP;
      ST_REMAP:    state_d = ST_LAD_SEL;
      ST_LAD_SEL: begin
        if (st_i.bypass) state_d = ST_PICK;
        else if (st_i.v_gt_one) state_d = ST_UP;
        else state_d = ST_DN_CHK;
      end
      ST_UP:       if (!st_i.up_more) state_d = ST_PICK;
      ST_DN_CHK:   state_d = st_i.dn_more ? ST_DN_DIV : ST_PICK;
      ST_DN_DIV:   if (st_i.div_last) state_d = ST_DN_END;
      ST_DN_END:   state_d = ST_DN_CHK;
      ST_PICK:     state_d = ST_MUL;
      ST_MUL:      state_d = st_i.tab_en ? ST_TAB_INIT : ST_FINAL;
      ST_TAB_INIT: state_d = ST_TAB;
      ST_TAB:      if (!st_i.tab_busy) state_d = ST_FINAL;
      ST_FINAL:    state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath command for the current state.
  always_comb begin
    op_o = OP_NONE;
    unique case (state_q)
      ST_IDLE:     if (start_i) op_o = OP_LOAD;
      ST_REMAP:    op_o = OP_REMAP;
      ST_LAD_SEL:  op_o = OP_NONE;
      ST_UP:       if (st_i.up_more) op_o = OP_UP_STEP;
      ST_DN_CHK:   if (st_i.dn_more) op_o = OP_DN_START;
      ST_DN_DIV:   op_o = OP_DN_BIT;
      ST_DN_END:   op_o = OP_DN_END;
      ST_PICK:     op_o = OP_LAD_PICK;
      ST_MUL:      op_o = OP_SCALE_MUL;
      ST_TAB_INIT: op_o = OP_TAB_INIT;
      ST_TAB:      if (st_i.tab_busy) op_o = OP_TAB_STEP;
      ST_FINAL:    op_o = OP_FINAL;
      default:     op_o = OP_NONE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

FILE: rtl/ssq_datapath.sv
// Arithmetic registers, multipliers, divider and table walk of the quantizer.
module ssq_datapath import ssq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  op_e         op_i,
  input  logic [9:0]  size_i,
  output dp_status_t  st_o,
  output logic        done_o,
  output logic [29:0] result_o
);

  logic [9:0]  size_q;
  logic [31:0] prod_q;
  logic        grow_q, shrink_q;
  logic [19:0] v_q;
  logic [32:0] low_q, high_q, s_q;
  logic [20:0] rem_q;
  logic [16:0] quo_q;
  logic [4:0]  cnt_q;
  logic [42:0] x_q;
  logic [3:0]  idx_q;
  logic        passed_q;
  logic        done_q;
  logic [29:0] result_q;

  logic [20:0] f;
  logic [19:0] diff;
  logic [19:0] ratio;
  logic [39:0] rprod;
  logic [32:0] gv;
  logic [19:0] v_new;
  logic [19:0] sv;
  logic [40:0] up_prod;
  logic [21:0] div_t;
  logic [3:0]  n_used;
  logic [42:0] fin;

  assign f = {1'b0, ONE_Q8} + {1'b0, cfg_i.stepping};

  // Remap product: grow or shrink distance times its ratio.
  always_comb begin
    if (cfg_i.scale > cfg_i.g_thr) begin
      diff  = cfg_i.scale - cfg_i.g_thr;
      ratio = cfg_i.g_ratio;
    end else begin
      diff  = cfg_i.s_thr - cfg_i.scale;
      ratio = cfg_i.s_ratio;
    end
    rprod = diff * ratio;
  end

  // Remapped scale with limits and saturation.
  always_comb begin
    gv = {1'b0, prod_q} + {13'b0, ONE_Q8};
    if ((cfg_i.g_lim != '0) && (gv > {13'b0, cfg_i.g_lim})) gv = {13'b0, cfg_i.g_lim};
    sv = ONE_Q8 - {11'b0, prod_q[8:0]};
    if (sv < cfg_i.s_lim) sv = cfg_i.s_lim;
    if (grow_q) begin
      v_new = (gv > {13'b0, SCALE_MAX}) ? SCALE_MAX : gv[19:0];
    end else if (shrink_q) begin
      v_new = (prod_q > {12'b0, ONE_Q8}) ? cfg_i.s_lim : sv;
    end else begin
      v_new = cfg_i.scale;
    end
  end

  assign up_prod = high_q[19:0] * f;
  assign div_t   = {rem_q, quo_q[16]};
  assign n_used  = (cfg_i.count > 4'(MAX_ALLOWED)) ? 4'(MAX_ALLOWED) : cfg_i.count;

  // Final value, before output saturation.
  always_comb begin
    if (n_used == '0) fin = x_q;
    else if (passed_q) fin = {10'b0, low_q};
    else fin = pick(x_q, {10'b0, low_q}, {10'b0, high_q}, cfg_i.rounding);
  end

  // Command execution.
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        size_q   <= size_i;
        prod_q   <= rprod[39:8];
        grow_q   <= cfg_i.scale > cfg_i.g_thr;
        shrink_q <= cfg_i.scale < cfg_i.s_thr;
      end
      OP_REMAP: begin
        v_q    <= v_new;
        low_q  <= {13'b0, ONE_Q8};
        high_q <= {13'b0, ONE_Q8};
      end
      OP_UP_STEP: begin
        low_q  <= high_q;
        high_q <= up_prod[40:8];
      end
      OP_DN_START: begin
        rem_q <= '0;
        quo_q <= {low_q[8:0], 8'b0};
        cnt_q <= '0;
      end
      OP_DN_BIT: begin
        if (div_t >= {1'b0, f}) begin
          rem_q <= 21'(div_t - {1'b0, f});
          quo_q <= {quo_q[15:0], 1'b1};
        end else begin
          rem_q <= div_t[20:0];
          quo_q <= {quo_q[15:0], 1'b0};
        end
        cnt_q <= cnt_q + 5'd1;
      end
      OP_DN_END: begin
        high_q <= low_q;
        low_q  <= {16'b0, quo_q};
      end
      OP_LAD_PICK: begin
        if (st_o.bypass) s_q <= {13'b0, v_q};
        else s_q <= 33'(pick({23'b0, v_q}, {10'b0, low_q}, {10'b0, high_q},
                             cfg_i.rounding));
      end
      OP_SCALE_MUL: x_q <= s_q * size_q;
      OP_TAB_INIT: begin
        low_q    <= {13'b0, entry(cfg_i.sizes, 3'd0)};
        high_q   <= {13'b0, entry(cfg_i.sizes, 3'd0)};
        idx_q    <= 4'd1;
        passed_q <= 1'b0;
      end
      OP_TAB_STEP: begin
        low_q <= high_q;
        if (idx_q >= n_used) begin
          passed_q <= 1'b1;
        end else begin
          high_q <= {13'b0, entry(cfg_i.sizes, idx_q[2:0])};
          idx_q  <= idx_q + 4'd1;
        end
      end
      OP_FINAL: result_q <= (fin > {13'b0, OUT_MAX}) ? OUT_MAX : fin[29:0];
      default: ;
    endcase
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (op_i == OP_FINAL);
    end
  end

  assign st_o.bypass   = (cfg_i.stepping == '0) || (v_q == ONE_Q8);
  assign st_o.v_gt_one = v_q > ONE_Q8;
  assign st_o.up_more  = high_q < {13'b0, v_q};
  assign st_o.dn_more  = low_q > {13'b0, v_q};
  assign st_o.div_last = cnt_q == 5'(DIV_STEPS - 1);
  assign st_o.tab_en   = n_used != '0;
  assign st_o.tab_busy = ({10'b0, high_q} < x_q) && !passed_q;

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

FILE: rtl/scaled_size_quantizer.sv
// Top level of the scaled size quantizer: registers, controller and datapath.
// A transaction starts when start is high while busy is low; the result
// appears on scaled_size_o with done_o, which is high for a single cycle, and
// the receiver cannot stall it. A new transaction can be taken in the cycle in
// which done_o is high. Where stepping is used, the stepping ladder dominates
// the length of a transaction: one multiply per rung going up (a few thousand
// rungs at most) and, per rung going down, a check, a restoring divide and an
// update (at most 256 rungs), plus a table load and one step per allowed size
// visited in the table walk. Configuration writes belong to idle time only.
module scaled_size_quantizer import ssq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  nominal_size_i,
  output logic        done_o,
  output logic [29:0] scaled_size_o
);

  cfg_t       cfg;
  op_e        op;
  dp_status_t st;
  logic       busy_w;

  ssq_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ssq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .st_i    (st),
    .op_o    (op),
    .busy_o  (busy_w)
  );

  ssq_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .op_i     (op),
    .size_i   (nominal_size_i),
    .st_o     (st),
    .done_o   (done_o),
    .result_o (scaled_size_o)
  );

  assign busy = busy_w;

  // An accepted transaction makes the block busy.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("start not taken");

  // The result strobe lasts exactly one cycle.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");

  // A result only follows a busy cycle and leaves the block idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy && $past(busy))) else $error("done out of sequence");

endmodule
